// File: rtl/core/mbrs_pkg.sv
// Package for the Modbus RTU slave responder: payload structs, protocol constants,
// controller/datapath command and status structs and the CRC-16 byte update.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none
package mbrs_pkg;

    typedef struct packed {
        logic        command;
        logic [7:0]  rx_byte;
        logic        frame_end;
        logic [7:0]  load_index;
        logic [15:0] load_value;
    } mbrs_in_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       led_zero;
        logic       led_one;
    } mbrs_out_t;

    localparam logic        CMD_RX_BYTE   = 1'b0;
    localparam logic        CMD_LOAD_REG  = 1'b1;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  FC_READ_REGS  = 8'd3;
    localparam logic [7:0]  FC_WRITE_REGS = 8'd16;
    localparam int          FC16_OVERHEAD = 9;
    localparam int          MIN_FRAME     = 8;
    localparam logic [7:0]  SLAVE_RESET   = 8'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic walk;
        logic check;
        logic load;
        logic advance;
    } mbrs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_done;
        logic walk_done;
        logic reply_ok;
        logic tx_last;
    } mbrs_stat_t;

    // One byte of the reflected CRC-16, one bit per step.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/mbrs_ctrl.sv
// Controller state machine of the Modbus RTU slave responder.
// Depends on mbrs_pkg; drives the datapath through mbrs_cmd_t, watches mbrs_stat_t.
`timescale 1ns / 1ps
`default_nettype none
module mbrs_ctrl
    import mbrs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    input  wire mbrs_stat_t stat,
    output mbrs_cmd_t       cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WALK  = 6'b000010,
        S_CHECK = 6'b000100,
        S_FETCH = 6'b001000,
        S_LOAD  = 6'b010000,
        S_SEND  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (stat.frame_done) begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (stat.walk_done) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                cmd.check  = 1'b1;
                state_next = stat.reply_ok ? S_FETCH : S_IDLE;
            end
            S_FETCH: begin
                // The holding register read issued here lands in the next cycle.
                state_next = S_LOAD;
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                state_next = S_SEND;
            end
            S_SEND: begin
                if (m_ready) begin
                    cmd.advance = 1'b1;
                    state_next  = stat.tx_last ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_SEND);

endmodule
`default_nettype wire

// File: rtl/core/mbrs_dp.sv
// Datapath of the Modbus RTU slave responder: frame store, holding registers,
// CRC walk, frame checks and response byte generation. Depends on mbrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbrs_dp
    import mbrs_pkg::*;
#(
    parameter int FRAME_DEPTH   = 256,
    parameter int MAX_READ_REGS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire mbrs_in_t   in_data,
    input  wire mbrs_cmd_t  cmd,
    output mbrs_stat_t      stat,
    output mbrs_out_t       out_data
);

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = $clog2(FRAME_DEPTH + 1);
    localparam int LW = $clog2(2 * MAX_READ_REGS + 10);

    logic [7:0]  frame_mem [FRAME_DEPTH];
    logic [15:0] hold_mem  [256];
    logic [255:0] hold_vld_reg;

    logic [7:0]    addr_reg;
    logic [CW-1:0] count_reg, n_reg, issue_reg, pidx_reg;
    logic          ovf_reg, n_ovf_reg, pv_reg;
    logic [15:0]   crc_reg, txcrc_reg;
    logic [7:0]    hdr_reg [9];
    logic [7:0]    rlo_reg, rhi_reg;
    logic [7:0]    fr_rd_reg;
    logic [15:0]   hold_rd_reg;
    logic          hold_rd_vld_reg;
    logic          led0_reg, led1_reg;
    logic          is_read_reg;
    logic [7:0]    idx_reg;
    logic [7:0]    bcnt_reg;
    logic [LW-1:0] len_reg, k_reg;
    mbrs_out_t     out_reg;

    logic [15:0] cnt;
    logic [17:0] flen;
    logic        base_ok, crc_good, rd_ok, wr_ok;
    logic [LW-1:0] j;
    logic [7:0]  hold_addr;
    logic [15:0] hold_val;
    logic [7:0]  tx_b;
    logic        last;

    assign cnt      = {hdr_reg[4], hdr_reg[5]};
    assign flen     = ({2'b00, cnt} << 1) + 18'(FC16_OVERHEAD);
    assign crc_good = (crc_reg == {rhi_reg, rlo_reg});
    assign base_ok  = !n_ovf_reg && (n_reg >= CW'(MIN_FRAME)) && (hdr_reg[0] == addr_reg);
    assign rd_ok    = base_ok && (hdr_reg[1] == FC_READ_REGS) && (n_reg == CW'(MIN_FRAME))
                      && (cnt <= 16'(MAX_READ_REGS)) && crc_good;
    assign wr_ok    = base_ok && (hdr_reg[1] == FC_WRITE_REGS)
                      && (flen <= 18'(FRAME_DEPTH)) && (18'(n_reg) == flen) && crc_good;

    assign j         = k_reg - LW'(3);
    assign hold_addr = idx_reg + 8'(j >> 1);
    assign hold_val  = hold_rd_vld_reg ? hold_rd_reg : 16'h0000;
    assign last      = (k_reg == len_reg - LW'(1));

    always_comb begin
        if (k_reg >= len_reg - LW'(2)) begin
            tx_b = (k_reg == len_reg - LW'(2)) ? txcrc_reg[7:0] : txcrc_reg[15:8];
        end else if (k_reg == '0) begin
            tx_b = addr_reg;
        end else if (!is_read_reg) begin
            tx_b = hdr_reg[4'(k_reg)];
        end else if (k_reg == LW'(1)) begin
            tx_b = FC_READ_REGS;
        end else if (k_reg == LW'(2)) begin
            tx_b = bcnt_reg;
        end else begin
            tx_b = j[0] ? hold_val[7:0] : hold_val[15:8];
        end
    end

    assign stat.frame_done = (in_data.command == CMD_RX_BYTE) && in_data.frame_end;
    assign stat.walk_done  = n_ovf_reg || (n_reg < CW'(MIN_FRAME))
                             || (pv_reg && (pidx_reg == n_reg - CW'(1)));
    assign stat.reply_ok   = rd_ok || wr_ok;
    assign stat.tx_last    = last;
    assign out_data        = out_reg;

    // Memories.
    always_ff @(posedge aclk) begin
        if (cmd.accept && (in_data.command == CMD_RX_BYTE) && (count_reg < CW'(FRAME_DEPTH))) begin
            frame_mem[count_reg[AW-1:0]] <= in_data.rx_byte;
        end
        fr_rd_reg <= frame_mem[issue_reg[AW-1:0]];
        if (cmd.accept && (in_data.command == CMD_LOAD_REG)) begin
            hold_mem[in_data.load_index] <= in_data.load_value;
        end
        hold_rd_reg <= hold_mem[hold_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_vld_reg    <= '0;
            hold_rd_vld_reg <= 1'b0;
            addr_reg        <= SLAVE_RESET;
            count_reg       <= '0;
            ovf_reg         <= 1'b0;
            n_reg           <= '0;
            n_ovf_reg       <= 1'b0;
            issue_reg       <= '0;
            pv_reg          <= 1'b0;
            led0_reg        <= 1'b1;
            led1_reg        <= 1'b1;
        end else begin
            hold_rd_vld_reg <= hold_vld_reg[hold_addr];
            if (cfg_we) begin
                addr_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                if (in_data.command == CMD_LOAD_REG) begin
                    hold_vld_reg[in_data.load_index] <= 1'b1;
                end else if (in_data.frame_end) begin
                    n_reg     <= (count_reg < CW'(FRAME_DEPTH)) ? count_reg + CW'(1) : count_reg;
                    n_ovf_reg <= ovf_reg || (count_reg >= CW'(FRAME_DEPTH));
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    issue_reg <= '0;
                    pv_reg    <= 1'b0;
                end else if (count_reg < CW'(FRAME_DEPTH)) begin
                    count_reg <= count_reg + CW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.walk) begin
                pv_reg <= (issue_reg < n_reg);
                if (issue_reg < n_reg) begin
                    issue_reg <= issue_reg + CW'(1);
                end
            end
            if (cmd.check && wr_ok && (cnt != 16'h0000)) begin
                case ({hdr_reg[7], hdr_reg[8]})
                    16'd0:   led0_reg <= 1'b0;
                    16'd1:   led0_reg <= 1'b1;
                    16'd2:   led1_reg <= 1'b0;
                    16'd3:   led1_reg <= 1'b1;
                    default: led0_reg <= led0_reg;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.accept && stat.frame_done) begin
            crc_reg <= CRC_INIT;
        end
        if (cmd.walk) begin
            pidx_reg <= issue_reg;
            if (pv_reg) begin
                if (pidx_reg < n_reg - CW'(2)) begin
                    crc_reg <= crc_byte(crc_reg, fr_rd_reg);
                end
                if (pidx_reg < CW'(9)) begin
                    hdr_reg[4'(pidx_reg)] <= fr_rd_reg;
                end
                if (pidx_reg == n_reg - CW'(2)) begin
                    rlo_reg <= fr_rd_reg;
                end
                if (pidx_reg == n_reg - CW'(1)) begin
                    rhi_reg <= fr_rd_reg;
                end
            end
        end
        if (cmd.check) begin
            is_read_reg <= rd_ok;
            idx_reg     <= hdr_reg[3];
            bcnt_reg    <= {cnt[6:0], 1'b0};
            len_reg     <= rd_ok ? (LW'({cnt[4:0], 1'b0}) + LW'(5)) : LW'(8);
            k_reg       <= '0;
            txcrc_reg   <= CRC_INIT;
        end
        if (cmd.load) begin
            out_reg.tx_byte  <= tx_b;
            out_reg.tx_last  <= last;
            out_reg.led_zero <= led0_reg;
            out_reg.led_one  <= led1_reg;
            if (k_reg < len_reg - LW'(2)) begin
                txcrc_reg <= crc_byte(txcrc_reg, tx_b);
            end
        end
        if (cmd.advance) begin
            k_reg <= k_reg + LW'(1);
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/modbus_rtu_slave_responder.sv
// Top level of the Modbus RTU slave responder: joins the controller and the datapath.
// Depends on mbrs_pkg, mbrs_ctrl and mbrs_dp.
//
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    mbrs_in_t  (command, frame byte, load data)
// m_        out        m_valid/m_ready    mbrs_out_t (response byte, last flag, LEDs)
// cfg_      in         cfg_we             cfg_wdata  (slave address)
//
// A load transaction or a frame byte without the end mark leaves the block ready for more.
// A frame end starts a walk over the stored frame through the store's single read
// port that reads every byte of a frame of eight bytes or more and stops at once for a
// shorter or overflowed frame; a check follows. A frame that passes is answered byte by
// byte (holding register read, byte build, output transaction), held by any m_ready stall.
// Reset is synchronous and active low; it clears the holding register valid bits,
// the byte count, sets both LEDs and the slave address to 5.
// s_ready is low from a frame end until the frame is rejected or the last response is taken.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_slave_responder
    import mbrs_pkg::*;
#(
    parameter int FRAME_DEPTH   = 256,
    parameter int MAX_READ_REGS = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_wdata,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire mbrs_in_t   s_payload,
    output logic            m_valid,
    input  wire logic       m_ready,
    output mbrs_out_t       m_payload
);

    mbrs_cmd_t  cmd;
    mbrs_stat_t stat;

    // The controller sequences receive, CRC walk, check and transmit phases.
    mbrs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath owns all storage and builds every response byte.
    mbrs_dp #(
        .FRAME_DEPTH   (FRAME_DEPTH),
        .MAX_READ_REGS (MAX_READ_REGS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_payload),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_payload)
    );

    // Input is never taken while a response byte is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a response is pending");

    // A transaction that ends no frame leaves the block ready for the next one.
    a_mid_frame_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_payload.command || !s_payload.frame_end)) |=> s_ready)
        else $error("block stalled after a transaction that ends no frame");

    // After the last response byte the block returns to receiving.
    a_last_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_payload.tx_last) |=> (s_ready && !m_valid))
        else $error("block did not return to receive after the last byte");

endmodule
`default_nettype wire
